@@ src/fpi_pkg.sv @@
// Shared types and constants for the piecewise interpolator.
// Used by the breakpoint cells, the divider stages and the top level.
package fpi_pkg;

  localparam int LANE_W     = 16;
  localparam int BANK_W     = 64;
  localparam int BANK_LANES = 4;
  localparam int SEG_W      = 5;
  localparam int IDX_W      = 4;
  localparam int OUT_W      = 16;
  localparam int SEGOUT_W   = 4;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_THR0 = 4'd0;
  localparam logic [IDX_W-1:0] REG_THR1 = 4'd1;
  localparam logic [IDX_W-1:0] REG_THR2 = 4'd2;
  localparam logic [IDX_W-1:0] REG_THR3 = 4'd3;
  localparam logic [IDX_W-1:0] REG_LVL0 = 4'd4;
  localparam logic [IDX_W-1:0] REG_LVL1 = 4'd5;
  localparam logic [IDX_W-1:0] REG_LVL2 = 4'd6;
  localparam logic [IDX_W-1:0] REG_LVL3 = 4'd7;

  // Control word that rides along with each sample
  typedef struct packed {
    logic             valid;
    logic             found;
    logic             clamp;
    logic [SEG_W-1:0] seg;
  } ctl_t;

endpackage

@@ src/fpi_cell.sv @@
// One breakpoint cell of the search chain.
// Depends on fpi_pkg (ctl_t).
module fpi_cell #(
  parameter int DW  = 16,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic signed [DW-1:0] thr,
  input  logic signed [DW-1:0] lvl,
  input  logic signed [DW-1:0] prv_thr,
  input  logic signed [DW-1:0] prv_lvl,
  input  fpi_pkg::ctl_t        ctl_in,
  input  logic signed [DW-1:0] e_in,
  input  logic signed [DW-1:0] t0_in,
  input  logic signed [DW-1:0] t1_in,
  input  logic signed [DW-1:0] l0_in,
  input  logic signed [DW-1:0] l1_in,
  output fpi_pkg::ctl_t        ctl,
  output logic signed [DW-1:0] e_out,
  output logic signed [DW-1:0] t0,
  output logic signed [DW-1:0] t1,
  output logic signed [DW-1:0] l0,
  output logic signed [DW-1:0] l1
);

  logic hit;
  fpi_pkg::ctl_t ctl_next;

  // first breakpoint at least the error claims the sample
  assign hit = !ctl_in.found && (e_in <= thr);

  always_comb begin
    ctl_next = ctl_in;
    if (hit) begin
      ctl_next.found = 1'b1;
      ctl_next.seg   = fpi_pkg::SEG_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_out <= e_in;
      if (hit) begin
        t0 <= prv_thr;
        t1 <= thr;
        l0 <= prv_lvl;
        l1 <= lvl;
      end else begin
        t0 <= t0_in;
        t1 <= t1_in;
        l0 <= l0_in;
        l1 <= l1_in;
      end
    end
  end

endmodule

@@ src/fpi_div_stage.sv @@
// One restoring-division stage: produces one quotient bit per cycle while en is high.
// Depends on fpi_pkg (ctl_t).
module fpi_div_stage #(
  parameter int DW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  fpi_pkg::ctl_t      ctl_in,
  input  logic [DW+1:0]      r_in,
  input  logic [DW-1:0]      low_in,
  input  logic [DW-1:0]      q_in,
  input  logic [DW:0]        d_in,
  input  logic               neg_in,
  input  logic [DW-1:0]      byp_in,
  output fpi_pkg::ctl_t      ctl,
  output logic [DW+1:0]      r,
  output logic [DW-1:0]      low,
  output logic [DW-1:0]      q,
  output logic [DW:0]        d,
  output logic               neg,
  output logic [DW-1:0]      byp
);

  logic [DW+1:0] trial;
  logic          ge;

  // shift in next numerator bit, subtract divisor if it fits
  assign trial = {r_in[DW:0], low_in[DW-1]};
  assign ge    = trial >= {1'b0, d_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r   <= ge ? (trial - {1'b0, d_in}) : trial;
      low <= {low_in[DW-2:0], 1'b0};
      q   <= {q_in[DW-2:0], ge};
      d   <= d_in;
      neg <= neg_in;
      byp <= byp_in;
    end
  end

endmodule

@@ src/fuzzy_piecewise_interpolator.sv @@
// Piecewise linear interpolator over programmable breakpoints, top level.
// Depends on fpi_pkg, fpi_cell and fpi_div_stage.
//
// Accepts one error sample every cycle while in_stall is low and returns one
// result per sample, in order. Each sample passes in turn through the
// breakpoint cells of the search chain, the multiply, sum and magnitude
// registers, the divider chain and the output register. The whole pipeline
// holds while a finished result is stalled at the output; in_stall is exactly
// that condition.
module fuzzy_piecewise_interpolator #(
  parameter int NUM_POINTS = 13,
  parameter int DATA_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [fpi_pkg::IDX_W-1:0]          wr_index,
  input  logic [fpi_pkg::BANK_W-1:0]         wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [fpi_pkg::LANE_W-1:0]  error_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fpi_pkg::OUT_W-1:0]   control_output,
  output logic [fpi_pkg::SEGOUT_W-1:0]       segment
);

  localparam int DW  = DATA_WIDTH;
  localparam int N   = NUM_POINTS;
  localparam int LW  = fpi_pkg::LANE_W;
  localparam int BW  = fpi_pkg::BANK_W;
  localparam int MW  = 2 * DW;

  // configuration banks
  logic [BW-1:0] thr0, thr1, thr2, lvl0, lvl1, lvl2;
  logic [LW-1:0] thr3, lvl3;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr0 <= '0; thr1 <= '0; thr2 <= '0; thr3 <= '0;
      lvl0 <= '0; lvl1 <= '0; lvl2 <= '0; lvl3 <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        fpi_pkg::REG_THR0: thr0 <= wr_data;
        fpi_pkg::REG_THR1: thr1 <= wr_data;
        fpi_pkg::REG_THR2: thr2 <= wr_data;
        fpi_pkg::REG_THR3: thr3 <= wr_data[LW-1:0];
        fpi_pkg::REG_LVL0: lvl0 <= wr_data;
        fpi_pkg::REG_LVL1: lvl1 <= wr_data;
        fpi_pkg::REG_LVL2: lvl2 <= wr_data;
        fpi_pkg::REG_LVL3: lvl3 <= wr_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // lane view: lanes past bank 3's single lane read as zero
  logic [4*BW-1:0] thr_all, lvl_all;
  assign thr_all = {(BW - LW)'(0), thr3, thr2, thr1, thr0};
  assign lvl_all = {(BW - LW)'(0), lvl3, lvl2, lvl1, lvl0};

  logic signed [DW-1:0] thr_lane [N];
  logic signed [DW-1:0] lvl_lane [N];

  for (genvar i = 0; i < N; i++) begin : g_lane
    assign thr_lane[i] = thr_all[i*LW +: DW];
    assign lvl_lane[i] = lvl_all[i*LW +: DW];
  end

  // global advance: everything moves unless the output is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // breakpoint search chain
  fpi_pkg::ctl_t        c_ctl [N+1];
  logic signed [DW-1:0] c_e   [N+1];
  logic signed [DW-1:0] c_t0  [N+1];
  logic signed [DW-1:0] c_t1  [N+1];
  logic signed [DW-1:0] c_l0  [N+1];
  logic signed [DW-1:0] c_l1  [N+1];

  always_comb begin
    c_ctl[0]       = '0;
    c_ctl[0].valid = in_valid;
    c_ctl[0].seg   = fpi_pkg::SEG_W'(N);
  end
  assign c_e[0]  = error_value[DW-1:0];
  assign c_t0[0] = '0;
  assign c_t1[0] = '0;
  assign c_l0[0] = '0;
  assign c_l1[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int P = (i == 0) ? 0 : i - 1;
    fpi_cell #(.DW(DW), .IDX(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .thr    (thr_lane[i]),
      .lvl    (lvl_lane[i]),
      .prv_thr(thr_lane[P]),
      .prv_lvl(lvl_lane[P]),
      .ctl_in (c_ctl[i]),
      .e_in   (c_e[i]),
      .t0_in  (c_t0[i]),
      .t1_in  (c_t1[i]),
      .l0_in  (c_l0[i]),
      .l1_in  (c_l1[i]),
      .ctl    (c_ctl[i+1]),
      .e_out  (c_e[i+1]),
      .t0     (c_t0[i+1]),
      .t1     (c_t1[i+1]),
      .l0     (c_l0[i+1]),
      .l1     (c_l1[i+1])
    );
  end

  // multiply stage: clamp decision, differences and both products
  fpi_pkg::ctl_t        ch_ctl, m_ctl_next, m_ctl;
  logic signed [DW-1:0] ch_byp;
  logic signed [DW:0]   diff_a, diff_b, diff_d;
  logic signed [2*DW:0] m_p0, m_p1;
  logic signed [DW:0]   m_d;
  logic [DW-1:0]        m_byp;

  assign ch_ctl = c_ctl[N];
  assign ch_byp = ch_ctl.found ? c_l1[N] : lvl_lane[N-1];
  assign diff_a = {c_t1[N][DW-1], c_t1[N]} - {c_e[N][DW-1], c_e[N]};
  assign diff_b = {c_e[N][DW-1], c_e[N]} - {c_t0[N][DW-1], c_t0[N]};
  assign diff_d = {c_t1[N][DW-1], c_t1[N]} - {c_t0[N][DW-1], c_t0[N]};

  always_comb begin
    m_ctl_next       = ch_ctl;
    m_ctl_next.clamp = !ch_ctl.found || (ch_ctl.seg == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_ctl <= '0;
    end else if (adv) begin
      m_ctl <= m_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_p0  <= diff_a * c_l0[N];
      m_p1  <= diff_b * c_l1[N];
      m_d   <= diff_d;
      m_byp <= ch_byp;
    end
  end

  // sum stage
  fpi_pkg::ctl_t          s_ctl;
  logic signed [2*DW+1:0] s_num;
  logic [DW:0]            s_d;
  logic [DW-1:0]          s_byp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_ctl <= '0;
    end else if (adv) begin
      s_ctl <= m_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_num <= {m_p0[2*DW], m_p0} + {m_p1[2*DW], m_p1};
      s_d   <= m_d;
      s_byp <= m_byp;
    end
  end

  // magnitude stage: split into divider start remainder and low bits
  fpi_pkg::ctl_t   v_ctl [DW+1];
  logic [DW+1:0]   v_r   [DW+1];
  logic [DW-1:0]   v_low [DW+1];
  logic [DW-1:0]   v_q   [DW+1];
  logic [DW:0]     v_d   [DW+1];
  logic            v_neg [DW+1];
  logic [DW-1:0]   v_byp [DW+1];
  logic [2*DW+1:0] mag_full;
  logic            num_neg;

  assign num_neg  = s_num[2*DW+1];
  assign mag_full = num_neg ? (-s_num) : s_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_ctl[0] <= '0;
    end else if (adv) begin
      v_ctl[0] <= s_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r[0]   <= {2'b00, mag_full[MW-1:DW]};
      v_low[0] <= mag_full[DW-1:0];
      v_q[0]   <= '0;
      v_d[0]   <= s_d;
      v_neg[0] <= num_neg;
      v_byp[0] <= s_byp;
    end
  end

  // divider chain, one quotient bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_div
    fpi_div_stage #(.DW(DW)) u_div (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .ctl_in(v_ctl[k]),
      .r_in  (v_r[k]),
      .low_in(v_low[k]),
      .q_in  (v_q[k]),
      .d_in  (v_d[k]),
      .neg_in(v_neg[k]),
      .byp_in(v_byp[k]),
      .ctl   (v_ctl[k+1]),
      .r     (v_r[k+1]),
      .low   (v_low[k+1]),
      .q     (v_q[k+1]),
      .d     (v_d[k+1]),
      .neg   (v_neg[k+1]),
      .byp   (v_byp[k+1])
    );
  end

  // output register: apply sign or pick the clamped level
  fpi_pkg::ctl_t ctl_f;
  logic [DW-1:0] q_signed;
  logic [DW-1:0] res_next;
  logic [DW-1:0] res;
  logic [fpi_pkg::SEG_W-1:0] seg_q;

  assign ctl_f    = v_ctl[DW];
  assign q_signed = v_neg[DW] ? (-v_q[DW]) : v_q[DW];
  assign res_next = ctl_f.clamp ? v_byp[DW] : q_signed;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_f.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res   <= res_next;
      seg_q <= ctl_f.seg;
    end
  end

  assign control_output = fpi_pkg::OUT_W'(res);
  assign segment        = seg_q[fpi_pkg::SEGOUT_W-1:0];

endmodule

@@ src/fpi_checker.sv @@
// Port-level checks for the piecewise interpolator, bound to the top level.
// Depends on fpi_pkg and fuzzy_piecewise_interpolator.
module fpi_checker #(
  parameter int NUM_POINTS = 13
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [fpi_pkg::OUT_W-1:0]    control_output,
  input logic [fpi_pkg::SEGOUT_W-1:0]        segment
);

  // a held result keeps its valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(control_output) && $stable(segment))
    else $error("result payload changed while stalled");

  // input back-pressure only comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output hold");

  // a valid segment never exceeds the breakpoint count, checked when that is below 16
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (NUM_POINTS < 16) |-> (32'(segment) <= NUM_POINTS))
    else $error("segment out of range");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fuzzy_piecewise_interpolator fpi_checker #(.NUM_POINTS(NUM_POINTS)) u_fpi_checker (.*);

@@ sim/fuzzy_piecewise_interpolator_tb.sv @@
// Self-checking testbench for the piecewise interpolator top level.
// Depends on fpi_pkg and fuzzy_piecewise_interpolator, which needs fpi_cell and fpi_div_stage.
module fuzzy_piecewise_interpolator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS        = 13;
  localparam int LATENCY     = NPTS + 16 + 4;
  localparam int HOLD_CYCLES = LATENCY * 3;

  typedef struct packed {
    logic signed [15:0] level;
    logic [3:0]         seg;
  } interp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [fpi_pkg::IDX_W-1:0] wr_index = fpi_pkg::REG_THR0;
  logic [fpi_pkg::BANK_W-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [fpi_pkg::LANE_W-1:0] error_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [fpi_pkg::OUT_W-1:0] control_output;
  logic [fpi_pkg::SEGOUT_W-1:0] segment;

  // Shadow copy of the register file
  logic [63:0] thr_bank [4];
  logic [63:0] lvl_bank [4];

  logic signed [15:0] sample_q [$];
  interp_t            expected_q [$];
  int  fail_count = 0;
  bit  hold_rx = 1'b0;
  bit  hold_tx = 1'b0;
  bit  tx_fire = 1'b0;

  fuzzy_piecewise_interpolator uut (
    .clk, .rst, .wr_en, .wr_index, .wr_data, .in_valid, .in_stall, .error_value,
    .out_valid, .out_stall, .control_output, .segment
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [15:0] lane_of(input logic [63:0] bank[4], input int i);
    logic [63:0] b;
    b = bank[i / 4];
    return b[(i % 4) * 16 +: 16];
  endfunction

  // Breakpoint search plus linear blend, truncated toward zero
  function automatic interp_t interpolate(input logic signed [15:0] e);
    interp_t r;
    int s;
    longint t0, t1, l0, l1, num;
    s = NPTS;
    for (int i = NPTS - 1; i >= 0; i--)
      if (e <= lane_of(thr_bank, i)) s = i;
    if (s == 0) begin
      r.level = lane_of(lvl_bank, 0);
    end else if (s == NPTS) begin
      r.level = lane_of(lvl_bank, NPTS - 1);
    end else begin
      t0 = lane_of(thr_bank, s - 1);
      t1 = lane_of(thr_bank, s);
      l0 = lane_of(lvl_bank, s - 1);
      l1 = lane_of(lvl_bank, s);
      num = (t1 - e) * l0 + (e - t0) * l1;
      r.level = 16'(num / (t1 - t0));
    end
    r.seg = 4'(s);
    return r;
  endfunction

  // Register write at a quiet moment; shadow follows
  task automatic write_reg(input logic [fpi_pkg::IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
    if (idx < fpi_pkg::REG_LVL0)
      thr_bank[idx] = (idx == fpi_pkg::REG_THR3) ? {48'd0, val[15:0]} : val;
    else
      lvl_bank[idx - fpi_pkg::REG_LVL0] = (idx == fpi_pkg::REG_LVL3) ? {48'd0, val[15:0]} : val;
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Kind 0: sorted breakpoints spaced randomly; 1: fully random; 2: evenly spaced, extreme levels; else a ramp
  task automatic program_table(input int kind);
    logic [15:0] t [13];
    logic [15:0] l [13];
    int base;
    base = -30000 + $urandom_range(0, 2000);
    for (int i = 0; i < 13; i++) begin
      case (kind)
        0: begin t[i] = 16'(base); base += $urandom_range(1, 4800); l[i] = 16'($urandom); end
        1: begin t[i] = 16'($urandom); l[i] = 16'($urandom); end
        2: begin t[i] = 16'(-32768 + i * 5461); l[i] = i[0] ? 16'h7fff : 16'h8000; end
        default: begin t[i] = 16'(i * 8 - 48); l[i] = 16'(i * 100 - 600); end
      endcase
    end
    write_reg(fpi_pkg::REG_THR0, {t[3], t[2], t[1], t[0]});
    write_reg(fpi_pkg::REG_THR1, {t[7], t[6], t[5], t[4]});
    write_reg(fpi_pkg::REG_THR2, {t[11], t[10], t[9], t[8]});
    write_reg(fpi_pkg::REG_THR3, {16'($urandom_range(0, 65535)), t[12]});
    write_reg(fpi_pkg::REG_LVL0, {l[3], l[2], l[1], l[0]});
    write_reg(fpi_pkg::REG_LVL1, {l[7], l[6], l[5], l[4]});
    write_reg(fpi_pkg::REG_LVL2, {l[11], l[10], l[9], l[8]});
    write_reg(fpi_pkg::REG_LVL3, {16'($urandom_range(0, 65535)), l[12]});
  endtask

  task automatic push_phase(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: sample_q.push_back(lane_of(thr_bank, $urandom_range(0, NPTS - 1)));
        1: sample_q.push_back(16'(lane_of(thr_bank, $urandom_range(0, NPTS - 1)) + 1));
        default: sample_q.push_back(16'($urandom));
      endcase
    end
    wait_drained();
  endtask

  task automatic push_phase_async();
    for (int i = 0; i < 80; i++) sample_q.push_back(16'($urandom));
  endtask

  // Sender: bursts with random gaps; sample changes only on a transfer
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (tx_fire) begin
        void'(sample_q.pop_front());
      end
      if (in_valid && !tx_fire) begin
        // stalled transfer holds its payload
      end else if (hold_tx || sample_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        error_value <= sample_q[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Expected result recorded on each input transfer
  always @(posedge clk) begin
    tx_fire <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) expected_q.push_back(interpolate(error_value));
  end

  // Receiver stall pattern, with one long hold-off counted here
  int rx_phase = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_rx && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (rx_phase[9:8] == 2'd0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Result checker
  always @(posedge clk) begin
    interp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result level=%0d seg=%0d", $time, control_output, segment);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (control_output !== want.level) begin
          $display("%0t: control_output expected %0d actual %0d",
                   $time, want.level, control_output);
          fail_count++;
        end
        if (segment !== want.seg) begin
          $display("%0t: segment expected %0d actual %0d", $time, want.seg, segment);
          fail_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) begin
      thr_bank[i] = '0;
      lvl_bank[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // All-zero table straight out of reset, then the directed extremes
    sample_q.push_back(16'sh8000);
    sample_q.push_back(16'sh7fff);
    sample_q.push_back(16'sh0000);
    sample_q.push_back(-16'sd1);
    wait_drained();
    program_table(3);
    sample_q.push_back(16'sh8000); sample_q.push_back(-16'sd48); sample_q.push_back(-16'sd47);
    sample_q.push_back(-16'sd44);  sample_q.push_back(-16'sd41); sample_q.push_back(16'sd0);
    sample_q.push_back(16'sd3);    sample_q.push_back(16'sd48);  sample_q.push_back(16'sd49);
    sample_q.push_back(16'sh7fff); sample_q.push_back(16'sh5555);
    sample_q.push_back(-16'sh5556);
    wait_drained();
    program_table(2);
    push_phase(20);

    // Long receiver hold-off while the sender keeps offering
    program_table(0);
    hold_rx = 1'b1;
    push_phase_async();
    wait_drained();
    hold_rx = 1'b0;

    // Random phases over sorted and unsorted tables; sender pause between them
    for (int p = 0; p < 12; p++) begin
      program_table((p % 3 == 2) ? 1 : 0);
      hold_tx = 1'b1;
      repeat ($urandom_range(1, 3)) @(negedge clk);
      hold_tx = 1'b0;
      push_phase(110);
    end

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
